>>> sv/ifsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Information frame framer package
// Shared types and constants: register map, reset values, byte slot layout of
// the per-item output burst, and the configuration and burst structures.
// ----------------------------------------------------------------------------
package ifsf_pkg;

    // One item can cause at most nine line bytes; each has a fixed slot.
    localparam int unsigned NUM_SLOTS = 9;
    localparam int unsigned SLOT_W    = 4;

    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_slot SLOT_OPEN  = 4'd0;  // opening flag
    localparam t_slot SLOT_ADDR  = 4'd1;  // address
    localparam t_slot SLOT_CTL   = 4'd2;  // control
    localparam t_slot SLOT_HCS   = 4'd3;  // header check
    localparam t_slot SLOT_DATA0 = 4'd4;  // payload byte or escape
    localparam t_slot SLOT_DATA1 = 4'd5;  // stuffed payload byte
    localparam t_slot SLOT_CHK0  = 4'd6;  // check byte or escape
    localparam t_slot SLOT_CHK1  = 4'd7;  // stuffed check byte
    localparam t_slot SLOT_CLOSE = 4'd8;  // closing flag

    localparam logic [7:0] STUFF_XOR  = 8'h20;
    localparam logic [7:0] CHECK_INIT = 8'h00;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLAG     = 3'd0,
        REG_ESCAPE   = 3'd1,
        REG_ADDRESS  = 3'd2,
        REG_CTL_SEQ0 = 3'd3,
        REG_CTL_SEQ1 = 3'd4
    } t_reg_idx;

    localparam logic [7:0] FLAG_RESET     = 8'h7E;
    localparam logic [7:0] ESCAPE_RESET   = 8'h7D;
    localparam logic [7:0] ADDRESS_RESET  = 8'h03;
    localparam logic [7:0] CTL_SEQ0_RESET = 8'h00;
    localparam logic [7:0] CTL_SEQ1_RESET = 8'h40;

    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] escape;
        logic [7:0] address;
        logic [7:0] ctl_seq0;
        logic [7:0] ctl_seq1;
    } t_cfg;

    // Line bytes caused by one item, with a mask of the slots in use.
    typedef struct packed {
        logic [NUM_SLOTS-1:0][7:0] bytes;
        logic [NUM_SLOTS-1:0]      mask;
    } t_burst;

endpackage

>>> sv/ifsf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer configuration registers
// Holds the flag, escape, address and the two control bytes.
// ----------------------------------------------------------------------------
module ifsf_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [ifsf_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [7:0]                        i_wr_data,
    output ifsf_pkg::t_cfg                    o_cfg
);

    ifsf_pkg::t_cfg r_cfg;
    ifsf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (ifsf_pkg::t_reg_idx'(i_wr_index))
                ifsf_pkg::REG_FLAG:     n_cfg.flag     = i_wr_data;
                ifsf_pkg::REG_ESCAPE:   n_cfg.escape   = i_wr_data;
                ifsf_pkg::REG_ADDRESS:  n_cfg.address  = i_wr_data;
                ifsf_pkg::REG_CTL_SEQ0: n_cfg.ctl_seq0 = i_wr_data;
                ifsf_pkg::REG_CTL_SEQ1: n_cfg.ctl_seq1 = i_wr_data;
                default:                n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag     <= ifsf_pkg::FLAG_RESET;
            r_cfg.escape   <= ifsf_pkg::ESCAPE_RESET;
            r_cfg.address  <= ifsf_pkg::ADDRESS_RESET;
            r_cfg.ctl_seq0 <= ifsf_pkg::CTL_SEQ0_RESET;
            r_cfg.ctl_seq1 <= ifsf_pkg::CTL_SEQ1_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/ifsf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer core
// Turns one input item into its burst of line bytes and keeps the frame state
// (open flag and running XOR check).
// ----------------------------------------------------------------------------
module ifsf_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_payload_byte,
    input  logic                i_has_data,
    input  logic                i_first_item,
    input  logic                i_last_item,
    input  logic                i_sequence_bit,
    input  ifsf_pkg::t_cfg      i_cfg,
    output ifsf_pkg::t_burst    o_burst
);

    logic [7:0] r_check;
    logic [7:0] n_check;
    logic       r_in_frame;
    logic       n_in_frame;

    logic [7:0] ctl;
    logic       open;
    logic       take;
    logic       close;
    logic [7:0] chk_base;
    logic [7:0] chk_new;
    logic       data_special;
    logic       chk_special;

    always_comb begin
        ctl          = i_sequence_bit ? i_cfg.ctl_seq1 : i_cfg.ctl_seq0;
        open         = i_first_item | r_in_frame;
        take         = open & i_has_data;
        close        = open & i_last_item;
        chk_base     = i_first_item ? ifsf_pkg::CHECK_INIT : r_check;
        chk_new      = take ? (chk_base ^ i_payload_byte) : chk_base;
        data_special = (i_payload_byte == i_cfg.escape) || (i_payload_byte == i_cfg.flag);
        chk_special  = (chk_new == i_cfg.escape) || (chk_new == i_cfg.flag);

        o_burst = '0;
        if (i_first_item) begin
            o_burst.bytes[ifsf_pkg::SLOT_OPEN] = i_cfg.flag;
            o_burst.bytes[ifsf_pkg::SLOT_ADDR] = i_cfg.address;
            o_burst.bytes[ifsf_pkg::SLOT_CTL]  = ctl;
            o_burst.bytes[ifsf_pkg::SLOT_HCS]  = ctl ^ i_cfg.address;
            o_burst.mask[ifsf_pkg::SLOT_OPEN]  = 1'b1;
            o_burst.mask[ifsf_pkg::SLOT_ADDR]  = 1'b1;
            o_burst.mask[ifsf_pkg::SLOT_CTL]   = 1'b1;
            o_burst.mask[ifsf_pkg::SLOT_HCS]   = 1'b1;
        end
        if (take) begin
            o_burst.mask[ifsf_pkg::SLOT_DATA0] = 1'b1;
            if (data_special) begin
                o_burst.bytes[ifsf_pkg::SLOT_DATA0] = i_cfg.escape;
                o_burst.bytes[ifsf_pkg::SLOT_DATA1] = i_payload_byte ^ ifsf_pkg::STUFF_XOR;
                o_burst.mask[ifsf_pkg::SLOT_DATA1]  = 1'b1;
            end else begin
                o_burst.bytes[ifsf_pkg::SLOT_DATA0] = i_payload_byte;
            end
        end
        if (close) begin
            o_burst.mask[ifsf_pkg::SLOT_CHK0]   = 1'b1;
            o_burst.mask[ifsf_pkg::SLOT_CLOSE]  = 1'b1;
            o_burst.bytes[ifsf_pkg::SLOT_CLOSE] = i_cfg.flag;
            if (chk_special) begin
                o_burst.bytes[ifsf_pkg::SLOT_CHK0] = i_cfg.escape;
                o_burst.bytes[ifsf_pkg::SLOT_CHK1] = chk_new ^ ifsf_pkg::STUFF_XOR;
                o_burst.mask[ifsf_pkg::SLOT_CHK1]  = 1'b1;
            end else begin
                o_burst.bytes[ifsf_pkg::SLOT_CHK0] = chk_new;
            end
        end

        n_check    = r_check;
        n_in_frame = r_in_frame;
        if (i_accept) begin
            n_check    = close ? ifsf_pkg::CHECK_INIT : chk_new;
            n_in_frame = open & ~close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check    <= ifsf_pkg::CHECK_INIT;
            r_in_frame <= 1'b0;
        end else begin
            r_check    <= n_check;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

>>> sv/ifsf_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer byte emitter
// Holds one burst and sends its used slots in order, one byte per transaction.
// ----------------------------------------------------------------------------
module ifsf_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ifsf_pkg::t_burst    i_burst,
    input  logic                i_out_ready,
    output logic                o_drained,
    output logic                o_out_valid,
    output logic [7:0]          o_line_byte,
    output logic                o_end_of_frame,
    output logic                o_last_of_run
);

    logic [ifsf_pkg::NUM_SLOTS-1:0][7:0] r_bytes;
    logic [ifsf_pkg::NUM_SLOTS-1:0]      r_mask;
    logic [ifsf_pkg::NUM_SLOTS-1:0]      n_mask;

    ifsf_pkg::t_slot cur;
    logic            one_left;
    logic            out_fire;

    // Lowest used slot is the next byte to send.
    always_comb begin
        cur = ifsf_pkg::SLOT_OPEN;
        for (int k = ifsf_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                cur = ifsf_pkg::SLOT_W'(k);
            end
        end
    end

    always_comb begin
        one_left  = (r_mask & (r_mask - ifsf_pkg::NUM_SLOTS'(1))) == '0;
        out_fire  = o_out_valid & i_out_ready;
        o_drained = ~o_out_valid | (out_fire & one_left);

        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_burst.mask;
        end else if (out_fire) begin
            n_mask = r_mask & ~(ifsf_pkg::NUM_SLOTS'(1) << cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
        end
    end

    assign o_out_valid    = |r_mask;
    assign o_line_byte    = r_bytes[cur];
    assign o_end_of_frame = (cur == ifsf_pkg::SLOT_CLOSE);
    assign o_last_of_run  = one_left;

endmodule

>>> sv/info_frame_stuffing_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Information frame stuffing framer
// Builds byte-stuffed information frames with an XOR block check from a
// stream of payload items.
// ----------------------------------------------------------------------------
// Each accepted input transaction is turned, in the same cycle, into the set
// of line bytes it causes (up to nine: a four-byte header on the first item,
// one or two bytes per stuffed payload byte, and on the last item one or two
// bytes of stuffed check followed by the closing flag). That set is latched
// into the emitter, which sends one byte per output transaction. An item
// therefore occupies the output until every byte it produces has been
// taken; an item that produces no bytes leaves the emitter empty. The
// output link is the limit: the next item is taken in the same cycle the
// last byte of the previous one leaves, so the line stays busy with no gap.
// Configuration writes are always accepted and should be issued only while
// the framer is idle.
// ----------------------------------------------------------------------------
module info_frame_stuffing_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Payload stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] payload_byte
    input  logic [2:0]  i_s_tuser,    // [0] has_data, [1] first_item, [2] sequence_bit
    input  logic        i_s_tlast,    // last_item

    // Line byte stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,    // [7:0] line_byte
    output logic [0:0]  o_m_tuser,    // [0] end_of_frame
    output logic        o_m_tlast,    // last_of_run

    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ifsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);

    ifsf_pkg::t_cfg   cfg;
    ifsf_pkg::t_burst burst;
    logic             drained;
    logic             in_accept;

    // Registers are plain flops, so every write transaction completes at once.
    assign o_cfg_ready = 1'b1;

    // A new item may enter whenever the emitter is empty or is sending its
    // final byte in this cycle.
    assign o_s_tready = drained;
    assign in_accept  = i_s_tvalid & drained;

    ifsf_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Header, stuffing and check logic; frame state advances on each
    // accepted transaction.
    ifsf_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_payload_byte (i_s_tdata),
        .i_has_data     (i_s_tuser[0]),
        .i_first_item   (i_s_tuser[1]),
        .i_last_item    (i_s_tlast),
        .i_sequence_bit (i_s_tuser[2]),
        .i_cfg          (cfg),
        .o_burst        (burst)
    );

    // Output register bank and slot sequencer.
    ifsf_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_accept),
        .i_burst        (burst),
        .i_out_ready    (i_m_tready),
        .o_drained      (drained),
        .o_out_valid    (o_m_tvalid),
        .o_line_byte    (o_m_tdata),
        .o_end_of_frame (o_m_tuser[0]),
        .o_last_of_run  (o_m_tlast)
    );

endmodule

>>> sv/ifsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer port checker
// Watches the framer's ports for reset, stall and framing rules.
// ----------------------------------------------------------------------------
module ifsf_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,
    input  logic [2:0]                       i_s_tuser,
    input  logic                             i_s_tlast,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [7:0]                       o_m_tdata,
    input  logic [0:0]                       o_m_tuser,
    input  logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    input  logic                             o_cfg_ready,
    input  logic [ifsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);

    // Reset leaves no line byte pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("line byte pending after reset");

    // A stalled line byte keeps its value and markers.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled line byte changed");

    // The closing flag is always the final byte of its item.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("closing flag not last of run");

    // With nothing waiting on the line side, the framer takes payload.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // An opening item always produces a header byte next cycle.
    a_first_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser[1] |=> o_m_tvalid && !o_m_tuser[0])
        else $error("opening item produced no header");

endmodule

bind info_frame_stuffing_framer ifsf_checker u_ifsf_checker (.*);
